// File: rtl/core/pip_pkg.sv
// Shared types and constants for the point-in-polygon test unit.
// Used by pip_front, pip_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    // Default sizing
    localparam int PIP_MAX_VERTICES = 64;
    localparam int PIP_COORD_BITS   = 16;

    // Item opcodes
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } pip_op_t;

    // Edge walker states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } pip_state_t;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic    valid;
        pip_op_t op;
    } pip_head_t;

endpackage

`default_nettype wire

// File: rtl/core/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the vertex stores.
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pip_front.sv
// Front end: accepts load and query transactions, drops loads aimed past the
// vertex store, and queues the rest in a two-entry queue. Depends on pip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pip_front import pip_pkg::*; #(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES,
    parameter int COORD_BITS   = PIP_COORD_BITS,
    localparam int IDX_W       = $clog2(MAX_VERTICES)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input transactions
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         opcode,
    input  wire logic        [IDX_W-1:0]      vertex_index,
    input  wire logic signed [COORD_BITS-1:0] x,
    input  wire logic signed [COORD_BITS-1:0] y,
    // queue head toward the back end
    output pip_head_t                         head,
    output logic             [IDX_W-1:0]      head_idx,
    output logic signed      [COORD_BITS-1:0] head_x,
    output logic signed      [COORD_BITS-1:0] head_y,
    input  wire logic                         take
);

    localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(MAX_VERTICES);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;

    pip_op_t                op_q_reg  [2];
    logic [IDX_W-1:0]       idx_q_reg [2];
    logic [COORD_BITS-1:0]  x_q_reg   [2];
    logic [COORD_BITS-1:0]  y_q_reg   [2];

    logic    accept;
    logic    keep;
    logic    deq;
    logic    idx_ok;
    pip_op_t in_op;

    // Classify the incoming transaction
    assign in_op  = pip_op_t'(opcode);
    assign idx_ok = {1'b0, vertex_index} < IDX_LIMIT;
    assign full   = (count_reg == 2'd2);
    assign accept = push && !full;
    assign keep   = accept && ((in_op == OP_QUERY) || idx_ok);
    assign deq    = take && (count_reg != 2'd0);

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (keep && !deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!keep && deq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (keep)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (deq)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store queued items
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            op_q_reg[wr_ptr_reg]  <= in_op;
            idx_q_reg[wr_ptr_reg] <= vertex_index;
            x_q_reg[wr_ptr_reg]   <= x;
            y_q_reg[wr_ptr_reg]   <= y;
        end
    end

    // Present the oldest item
    assign head.valid = (count_reg != 2'd0);
    assign head.op    = op_q_reg[rd_ptr_reg];
    assign head_idx   = idx_q_reg[rd_ptr_reg];
    assign head_x     = $signed(x_q_reg[rd_ptr_reg]);
    assign head_y     = $signed(y_q_reg[rd_ptr_reg]);

endmodule

`default_nettype wire

// File: rtl/core/pip_back.sv
// Back end: holds the vertex count, writes vertices into the stores and walks
// the polygon edges through a four-stage compare pipeline for each query.
// Depends on pip_pkg and pip_ram.
`timescale 1ns / 1ps
`default_nettype none

module pip_back import pip_pkg::*; #(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES,
    parameter int COORD_BITS   = PIP_COORD_BITS,
    localparam int IDX_W       = $clog2(MAX_VERTICES),
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CNT_W-1:0]      vertex_count,
    // queue head from the front end
    input  wire pip_head_t                    head,
    input  wire logic        [IDX_W-1:0]      head_idx,
    input  wire logic signed [COORD_BITS-1:0] head_x,
    input  wire logic signed [COORD_BITS-1:0] head_y,
    output logic                              take,
    // results
    input  wire logic                         pop,
    output logic                              empty,
    output logic                              inside_res
);

    localparam int D_W = COORD_BITS + 1;
    localparam int P_W = 2 * D_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    pip_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] n_minus1;

    logic [IDX_W-1:0]             i_reg;
    logic [IDX_W-1:0]             last_reg;
    logic                         first_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;

    // walker controls
    logic             start;
    logic             zero_done;
    logic             ram_we;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             issue_edge;
    logic             issue_last;

    // store read data
    logic [COORD_BITS-1:0]        rd_x, rd_y;
    logic signed [COORD_BITS-1:0] xi, yi, xj, yj;
    logic [COORD_BITS-1:0]        prev_x_reg, prev_y_reg;

    // pipeline
    logic                s1_valid_reg, s1_edge_reg, s1_last_reg;
    logic                s2_valid_reg, s2_last_reg, s2_hit_reg, s2_up_reg;
    logic signed [D_W-1:0] a_reg, dy_reg, c_reg, d_reg;
    logic                s3_valid_reg, s3_last_reg, s3_hit_reg, s3_up_reg;
    logic signed [P_W-1:0] p1_reg, p2_reg;
    logic                span;
    logic                left;
    logic                toggle;
    logic                inside_reg;
    logic                inside_next;

    logic res_valid_reg;
    logic res_reg;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= vertex_count;
        end
    end

    // Clamp the count to the store depth
    assign n_eff    = (count_reg > CNT_MAX) ? CNT_MAX : count_reg;
    assign n_minus1 = n_eff - CNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && (head.op == OP_QUERY) && !res_valid_reg
                    && (n_eff != '0))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (!first_reg && (i_reg == last_reg))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s3_valid_reg && s3_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Walker outputs
    always_comb
    begin
        take       = 1'b0;
        start      = 1'b0;
        zero_done  = 1'b0;
        ram_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = i_reg;
        issue_edge = 1'b0;
        issue_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.op == OP_LOAD)
                    begin
                        take   = 1'b1;
                        ram_we = 1'b1;
                    end
                    else if (!res_valid_reg)
                    begin
                        take      = 1'b1;
                        start     = (n_eff != '0);
                        zero_done = (n_eff == '0);
                    end
                end
            end
            ST_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_addr    = first_reg ? last_reg : i_reg;
                issue_edge = !first_reg;
                issue_last = !first_reg && (i_reg == last_reg);
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // State and edge counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                i_reg     <= '0;
                first_reg <= 1'b1;
            end
            else if (state_reg == ST_ISSUE)
            begin
                if (first_reg)
                begin
                    first_reg <= 1'b0;
                end
                else
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
            end
        end
    end

    // Latch the query point and last vertex index
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            px_reg   <= head_x;
            py_reg   <= head_y;
            last_reg <= n_minus1[IDX_W-1:0];
        end
    end

    // Vertex stores
    pip_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_x_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (head_idx),
        .wr_data (head_x),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_x)
    );

    pip_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_y_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (head_idx),
        .wr_data (head_y),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_y)
    );

    // Stage 1: read data arrives, pair it with the previous vertex
    assign xi = $signed(rd_x);
    assign yi = $signed(rd_y);
    assign xj = $signed(prev_x_reg);
    assign yj = $signed(prev_y_reg);
    assign span = ((yi <= py_reg) && (py_reg < yj)) || ((yj <= py_reg) && (py_reg < yi));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
    end

    // Stage 2: coordinate differences
    always_ff @(posedge clk)
    begin
        a_reg     <= {px_reg[COORD_BITS-1], px_reg} - {xi[COORD_BITS-1], xi};
        dy_reg    <= {yj[COORD_BITS-1], yj} - {yi[COORD_BITS-1], yi};
        c_reg     <= {xj[COORD_BITS-1], xj} - {xi[COORD_BITS-1], xi};
        d_reg     <= {py_reg[COORD_BITS-1], py_reg} - {yi[COORD_BITS-1], yi};
        s2_hit_reg <= s1_edge_reg && span;
        s2_up_reg  <= (yj > yi);
        s2_last_reg <= s1_last_reg;
    end

    // Stage 3: cross products
    always_ff @(posedge clk)
    begin
        p1_reg      <= P_W'(a_reg) * P_W'(dy_reg);
        p2_reg      <= P_W'(c_reg) * P_W'(d_reg);
        s3_hit_reg  <= s2_hit_reg;
        s3_up_reg   <= s2_up_reg;
        s3_last_reg <= s2_last_reg;
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_edge_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            s1_edge_reg  <= issue_edge;
            s1_last_reg  <= issue_last;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 4: crossing decision, flipped by the edge direction
    assign left        = s3_up_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg);
    assign toggle      = s3_valid_reg && s3_hit_reg && left;
    assign inside_next = inside_reg ^ toggle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
        end
        else if (start)
        begin
            inside_reg <= 1'b0;
        end
        else
        begin
            inside_reg <= inside_next;
        end
    end

    // Result slot: fill at the last edge or for an empty polygon, drop on pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (zero_done || (s3_valid_reg && s3_last_reg))
        begin
            res_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (zero_done)
        begin
            res_reg <= 1'b0;
        end
        else if (s3_valid_reg && s3_last_reg)
        begin
            res_reg <= inside_next;
        end
    end

    assign empty      = !res_valid_reg;
    assign inside_res = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: front-end queue and back-end
// edge walker. Depends on pip_pkg, pip_front, pip_back and pip_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  items in  | push / full          | opcode, vertex_index, x, y
//  results   | empty / pop          | inside_res
//  config    | cfg_valid / cfg_ready| vertex_count
//
// A load is taken by the edge walker straight from the queue head. A query over
// n vertices makes n + 1 store reads, one per cycle on the single read port,
// then passes four pipeline stages; a count of zero answers without a store read.
// Reset clears control state only; the vertex stores need no clearing pass.
// Two transactions can wait in the input queue while the walker is busy, and
// a new query starts only after the previous result has been popped.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_unit import pip_pkg::*; #(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES,
    parameter int COORD_BITS   = PIP_COORD_BITS,
    localparam int IDX_W       = $clog2(MAX_VERTICES),
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CNT_W-1:0]      vertex_count,
    // items
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         opcode,
    input  wire logic        [IDX_W-1:0]      vertex_index,
    input  wire logic signed [COORD_BITS-1:0] x,
    input  wire logic signed [COORD_BITS-1:0] y,
    // results
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              inside_res
);

    pip_head_t                    head;
    logic [IDX_W-1:0]             head_idx;
    logic signed [COORD_BITS-1:0] head_x, head_y;
    logic                         take;

    pip_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .vertex_index (vertex_index),
        .x            (x),
        .y            (y),
        .head         (head),
        .head_idx     (head_idx),
        .head_x       (head_x),
        .head_y       (head_y),
        .take         (take)
    );

    pip_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .vertex_count (vertex_count),
        .head         (head),
        .head_idx     (head_idx),
        .head_x       (head_x),
        .head_y       (head_y),
        .take         (take),
        .pop          (pop),
        .empty        (empty),
        .inside_res   (inside_res)
    );

endmodule

`default_nettype wire

// File: rtl/core/pip_checker.sv
// Port-level checks for the point-in-polygon test unit, bound to the top
// level. Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire logic full,
    input wire logic pop,
    input wire logic empty,
    input wire logic inside_res
);

    // Reset leaves both queues open and empty
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> (empty && !full))
        else $error("queues not clear during reset");

    // Hold a waiting result until it is popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(inside_res)))
        else $error("waiting result changed or vanished");

    // The input queue fills only after a push transaction
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue filled without a push");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .inside_res (inside_res)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for point_in_polygon_test_unit: crossing-number predictor,
// queue-style item and result drivers, and directed plus random polygon tests.
// Depends on pip_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
    import pip_pkg::*;

    localparam int IDX_W       = $clog2(PIP_MAX_VERTICES);
    localparam int CNT_W       = $clog2(PIP_MAX_VERTICES + 1);
    localparam int CW          = PIP_COORD_BITS;
    localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (CW - 1));
    localparam int ITEM_TARGET = 1400;
    localparam int SETTLE      = 80;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        pip_op_t               op;
        logic [IDX_W-1:0]      idx;
        logic signed [CW-1:0]  px;
        logic signed [CW-1:0]  py;
    } pip_item_t;

    // DUT signals
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      vertex_count = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  opcode = 1'b0;
    logic [IDX_W-1:0]      vertex_index = '0;
    logic signed [CW-1:0]  pt_x = '0;
    logic signed [CW-1:0]  pt_y = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  inside_res;

    // Shadow state of the block
    logic signed [CW-1:0]  vertex_x_mem [PIP_MAX_VERTICES];
    logic signed [CW-1:0]  vertex_y_mem [PIP_MAX_VERTICES];
    logic [CNT_W-1:0]      count_shadow = '0;

    // Pending items and expected inside bits
    pip_item_t             item_q [$];
    logic                  inside_expect_q [$];

    // Bookkeeping
    int  items_queued = 0;
    int  items_accepted = 0;
    int  loads_done = 0;
    int  queries_done = 0;
    int  inside_hits = 0;
    int  cfg_writes = 0;
    int  mismatches = 0;
    int  cycle_cnt = 0;
    bit  gaps_on = 1'b1;
    bit  holding = 1'b0;
    int  hold_len = 0;

    // Current polygon window used by the probes
    int  win_cx = 0;
    int  win_cy = 0;
    int  win_w = 1;
    int  poly_n = 1;

    point_in_polygon_test_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .vertex_count (vertex_count),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .vertex_index (vertex_index),
        .x            (pt_x),
        .y            (pt_y),
        .empty        (empty),
        .pop          (pop),
        .inside_res   (inside_res)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Odd number of edge crossings right of the point, exact in integers
    function automatic logic crossing_parity(input logic signed [CW-1:0] px,
                                             input logic signed [CW-1:0] py);
        longint lpx, lpy, xi, yi, xj, yj, dy, lhs, rhs;
        int     n, i, j;
        logic   odd;
        lpx = longint'(px);
        lpy = longint'(py);
        n   = (count_shadow > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : int'(count_shadow);
        odd = 1'b0;
        j   = n - 1;
        for (i = 0; i < n; i++)
        begin
            xi = longint'(vertex_x_mem[i]);
            yi = longint'(vertex_y_mem[i]);
            xj = longint'(vertex_x_mem[j]);
            yj = longint'(vertex_y_mem[j]);
            if ((yi <= lpy && lpy < yj) || (yj <= lpy && lpy < yi))
            begin
                dy  = yj - yi;
                lhs = (lpx - xi) * dy;
                rhs = (xj - xi) * (lpy - yi);
                if (dy > 0 ? (lhs < rhs) : (lhs > rhs))
                    odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input int v);
        if (v > COORD_MAX)
            return CW'(COORD_MAX);
        if (v < COORD_MIN)
            return CW'(COORD_MIN);
        return CW'(v);
    endfunction

    // Uniform offset in [-w, w]
    function automatic int spread(input int w);
        return int'($urandom_range(2 * w)) - w;
    endfunction

    // Offer queued items; update the shadow state on each accepted transaction
    always @(posedge clk)
    begin : item_driver
        pip_item_t head;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                head = item_q.pop_front();
                items_accepted++;
                if (head.op == OP_LOAD)
                begin
                    vertex_x_mem[head.idx] = head.px;
                    vertex_y_mem[head.idx] = head.py;
                    loads_done++;
                end
                else
                begin
                    inside_expect_q = {inside_expect_q, crossing_parity(head.px, head.py)};
                    if (inside_expect_q[$])
                        inside_hits++;
                    queries_done++;
                end
            end
            // hold an offered item until taken; otherwise pick the next or idle
            if (!push || !full)
            begin
                if (item_q.size() != 0 && !(gaps_on && $urandom_range(99) < 11))
                begin
                    push         <= 1'b1;
                    opcode       <= item_q[0].op;
                    vertex_index <= item_q[0].idx;
                    pt_x         <= item_q[0].px;
                    pt_y         <= item_q[0].py;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Take results and compare against the oldest expectation
    always @(posedge clk)
    begin : result_checker
        logic want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (inside_expect_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("MISMATCH: result %b with no query outstanding", inside_res);
                    mismatches++;
                end
                else
                begin
                    want = inside_expect_q.pop_front();
                    if (inside_res !== want)
                    begin
                        if (mismatches < 10)
                            $display("MISMATCH: inside_res expected %b actual %b",
                                     want, inside_res);
                        mismatches++;
                    end
                end
            end
            pop <= !holding && !(gaps_on && $urandom_range(99) < 11);
        end
    end

    // Hold off the result side whenever hold_len is set, then clear hold_len
    always
    begin : hold_timer
        wait (hold_len > 0);
        holding = 1'b1;
        repeat (hold_len) @(posedge clk);
        holding  = 1'b0;
        hold_len = 0;
    end

    // End the run if it hangs
    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[point_in_polygon_test_unit] ERROR");
        $finish;
    end

    task automatic send_item(input pip_op_t op, input int idx, input int px, input int py);
        pip_item_t it;
        it.op  = op;
        it.idx = idx[IDX_W-1:0];
        it.px  = clamp_coord(px);
        it.py  = clamp_coord(py);
        while (item_q.size() >= 2)
            @(posedge clk);
        item_q = {item_q, it};
        items_queued++;
    endtask

    // Wait until every item is taken and every result has come back
    task automatic wait_drain();
        while (items_accepted != items_queued || inside_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the vertex count once the block is idle
    task automatic set_vertex_count(input int v);
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid    <= 1'b1;
        vertex_count <= v[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        count_shadow = v[CNT_W-1:0];
        cfg_valid   <= 1'b0;
        cfg_writes++;
    endtask

    // Load n vertices into slots 0..n-1, on a square outline or scattered
    task automatic load_polygon(input int n, input int w, input bit shaped);
        int k, s, vx, vy;
        win_w  = w;
        win_cx = (w >= COORD_MAX) ? 0 : spread(COORD_MAX - w);
        win_cy = (w >= COORD_MAX) ? 0 : spread(COORD_MAX - w);
        poly_n = n;
        for (k = 0; k < n; k++)
        begin
            if (shaped)
            begin
                s = (k * 8 * w) / n;
                if (s < 2 * w)
                begin
                    vx = -w + s;
                    vy = -w;
                end
                else if (s < 4 * w)
                begin
                    vx = w;
                    vy = -w + (s - 2 * w);
                end
                else if (s < 6 * w)
                begin
                    vx = w - (s - 4 * w);
                    vy = w;
                end
                else
                begin
                    vx = -w;
                    vy = w - (s - 6 * w);
                end
                vx += spread(w / 16);
                vy += spread(w / 16);
            end
            else
            begin
                vx = spread(w);
                vy = spread(w);
            end
            send_item(OP_LOAD, k, win_cx + vx, win_cy + vy);
        end
    endtask

    // One random item, mostly aimed at the current polygon
    task automatic send_probe();
        int pick, k, reach;
        pick  = $urandom_range(99);
        k     = $urandom_range(poly_n - 1);
        reach = win_w + win_w / 4 + 1;
        if (pick < 55)
            send_item(OP_QUERY, $urandom_range(63), win_cx + spread(reach),
                      win_cy + spread(reach));
        else if (pick < 75)
            send_item(OP_QUERY, $urandom_range(63), win_cx + spread(reach),
                      int'(vertex_y_mem[k]));
        else if (pick < 85)
            send_item(OP_QUERY, $urandom_range(63), int'(vertex_x_mem[k]),
                      int'(vertex_y_mem[k]));
        else if (pick < 95)
            send_item(OP_QUERY, $urandom_range(63), spread(32768), spread(32768));
        else
            send_item(OP_LOAD, $urandom_range(63), win_cx + spread(win_w),
                      win_cy + spread(win_w));
    endtask

    // Count of zero answers outside without reading the store
    task automatic test_empty_polygon();
        set_vertex_count(0);
        send_item(OP_QUERY, 63, 0, 0);
        send_item(OP_QUERY, 0, COORD_MIN, COORD_MAX);
    endtask

    // Square with points on edges, on a vertex and on horizontal edges
    task automatic test_square_edges();
        send_item(OP_LOAD, 0, -100, -100);
        send_item(OP_LOAD, 1, 100, -100);
        send_item(OP_LOAD, 2, 100, 100);
        send_item(OP_LOAD, 3, -100, 100);
        set_vertex_count(4);
        send_item(OP_QUERY, 0, 0, 0);
        send_item(OP_QUERY, 0, -100, 0);
        send_item(OP_QUERY, 0, 100, 0);
        send_item(OP_QUERY, 0, 0, -100);
        send_item(OP_QUERY, 0, 0, 100);
        send_item(OP_QUERY, 0, -100, -100);
    endtask

    // One and two vertices walk the same edges and stay outside
    task automatic test_degenerate_counts();
        set_vertex_count(1);
        send_item(OP_QUERY, 0, -100, -100);
        set_vertex_count(2);
        send_item(OP_QUERY, 0, 0, -100);
    endtask

    // Triangle spanning the full coordinate range
    task automatic test_extreme_coords();
        send_item(OP_LOAD, 0, COORD_MIN, COORD_MIN);
        send_item(OP_LOAD, 1, COORD_MAX, COORD_MIN);
        send_item(OP_LOAD, 2, COORD_MIN, COORD_MAX);
        set_vertex_count(3);
        send_item(OP_QUERY, 0, COORD_MAX, COORD_MAX);
        send_item(OP_QUERY, 0, COORD_MIN, COORD_MIN);
        send_item(OP_QUERY, 0, 0, 0);
        send_item(OP_QUERY, 0, COORD_MIN, 0);
    endtask

    // Fill every slot; run the largest count and a saturating one
    task automatic test_full_store();
        load_polygon(PIP_MAX_VERTICES, 20000, 1'b1);
        set_vertex_count(PIP_MAX_VERTICES);
        repeat (8) send_probe();
        set_vertex_count((1 << CNT_W) - 1);
        repeat (8) send_probe();
    endtask

    // Stall results long enough to fill the block, then pause until drained
    task automatic test_backpressure();
        load_polygon(5, 300, 1'b1);
        set_vertex_count(5);
        hold_len = 400;
        repeat (30) send_probe();
        wait_drain();
        repeat (20) send_probe();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_back_to_back();
        wait_drain();
        gaps_on = 1'b0;
        repeat (150) send_probe();
        wait_drain();
        gaps_on = 1'b1;
    endtask

    // Random polygons, counts and probes until the item budget is used
    task automatic test_random_polygons();
        int r, n, w, probes;
        while (items_queued < ITEM_TARGET)
        begin
            r = $urandom_range(99);
            if (r < 5)
                n = 1 + $urandom_range(1);
            else if (r < 75)
                n = $urandom_range(8, 3);
            else if (r < 95)
                n = $urandom_range(20, 9);
            else
                n = PIP_MAX_VERTICES;
            case ($urandom_range(3))
                0: w = 4;
                1: w = 300;
                2: w = 20000;
                default: w = COORD_MAX;
            endcase
            load_polygon(n, w, $urandom_range(1));
            r = $urandom_range(99);
            if (r < 85)
                set_vertex_count(n);
            else if (r < 92)
                set_vertex_count($urandom_range((1 << CNT_W) - 1));
            probes = (n > 20) ? 8 : $urandom_range(45, 25);
            repeat (probes) send_probe();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_polygon();
        test_square_edges();
        test_degenerate_counts();
        test_extreme_coords();
        test_full_store();
        test_backpressure();
        test_back_to_back();
        test_random_polygons();

        wait_drain();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d vertex loads and %0d queries (%0d inside) over %0d count writes,",
                 loads_done, queries_done, inside_hits, cfg_writes);
        $display("including empty, degenerate, full and saturated counts; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && inside_expect_q.size() == 0)
            $display("[point_in_polygon_test_unit] OK");
        else
            $display("[point_in_polygon_test_unit] ERROR");
        $finish;
    end

endmodule
